/* hdl/aid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_pkg
// shared codes and defaults for the word array core
// ----------------------------------------------------------------------------
package aid_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int WORD_W        = 32;

   localparam logic [2:0] OP_INSERT   = 3'd0;
   localparam logic [2:0] OP_APPEND   = 3'd1;
   localparam logic [2:0] OP_DELETE   = 3'd2;
   localparam logic [2:0] OP_SORT_ASC = 3'd3;
   localparam logic [2:0] OP_SORT_DSC = 3'd4;
   localparam logic [2:0] OP_AVERAGE  = 3'd5;
   localparam logic [2:0] OP_READ     = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

endpackage

/* hdl/aid_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_ram
// word store, one write port and one registered read port
// ----------------------------------------------------------------------------
module aid_ram import aid_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WORD_W-1:0]        wr_data,
   input  logic [AW-1:0]            rd_addr,
   output logic signed [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hdl/aid_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module aid_div import aid_pkg::*; #(
   parameter int SW = 38,
   parameter int CW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [SW-1:0] dividend,
   input  logic [CW-1:0] divisor,
   output logic          done,
   output logic [SW-1:0] quotient
);

   localparam int NW = $clog2(SW + 1);

   logic [NW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [SW-1:0] q_ff, q_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW:0]   shifted;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, q_ff[SW-1]};
      if (start) begin
         cnt_in = NW'(SW);
         q_in   = dividend;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == NW'(1));
         if (shifted >= {1'b0, divisor}) begin
            rem_in = CW'(shifted - {1'b0, divisor});
            q_in   = {q_ff[SW-2:0], 1'b1};
         end else begin
            rem_in = shifted[CW-1:0];
            q_in   = {q_ff[SW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

/* hdl/array_insert_delete_sort_average_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_insert_delete_sort_average_core
// ordered word array with insert, append, delete, sort, average and read
// ----------------------------------------------------------------------------
// usage:
//   a command is taken on a clock edge with start high and busy low; busy
//   stays high until the command has finished. every command gives one
//   response, shown for one cycle with rsp_strobe high; it cannot be held.
// command flow (n words held, all through the single word memory):
//   append, errors: answered straight from idle
//   read: one memory read; insert/delete: a read and a write per shifted word
//   average: read loop over all n words, then a bit-serial divider of
//     32 + count width steps; sort: insertion sort, a read and a write per
//     compare and move, worst for reverse ordered data
// a new command may be given in the cycle its predecessor's response shows.
// reset clears the word count and the control; memory contents are left.
// ----------------------------------------------------------------------------
module array_insert_delete_sort_average_core import aid_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_operation,
   input  logic [5:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_count,
   output logic signed [31:0] rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 6) ? CW : 6;
   localparam int SW = WORD_W + CW;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_RD  = 4'd1;
   localparam logic [3:0] S_INS_WR  = 4'd2;
   localparam logic [3:0] S_DEL_RD  = 4'd3;
   localparam logic [3:0] S_DEL_WR  = 4'd4;
   localparam logic [3:0] S_SRT_KEY = 4'd5;
   localparam logic [3:0] S_SRT_KW  = 4'd6;
   localparam logic [3:0] S_SRT_RD  = 4'd7;
   localparam logic [3:0] S_SRT_CMP = 4'd8;
   localparam logic [3:0] S_AVG_RD  = 4'd9;
   localparam logic [3:0] S_AVG_ACC = 4'd10;
   localparam logic [3:0] S_AVG_DIV = 4'd11;
   localparam logic [3:0] S_RD_OUT  = 4'd12;

   logic [3:0]               state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            j_ff, j_in;
   logic [XW-1:0]            pos_ff, pos_in;
   logic signed [WORD_W-1:0] val_ff, val_in;
   logic signed [WORD_W-1:0] key_ff, key_in;
   logic                     desc_ff, desc_in;
   logic signed [SW-1:0]     sum_ff, sum_in;
   logic                     strobe_ff, strobe_in;
   logic [1:0]               status_ff, status_in;
   logic signed [WORD_W-1:0] data_ff, data_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [WORD_W-1:0]        wr_data;
   logic signed [WORD_W-1:0] rd_data;
   logic                     div_start, div_done;
   logic [SW-1:0]            div_mag, div_q, avg_full;
   logic                     sum_neg;
   logic [XW-1:0]            req_pos_x, count_x;
   logic                     full, empty;

   aid_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   aid_div #(.SW(SW), .CW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_mag),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign sum_neg   = sum_ff[SW-1];
   assign div_mag   = sum_neg ? SW'(-sum_ff) : SW'(sum_ff);
   assign avg_full  = sum_neg ? SW'(-div_q) : div_q;
   assign req_pos_x = XW'(req_position);
   assign count_x   = XW'(count_ff);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      j_in      = j_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      key_in    = key_ff;
      desc_in   = desc_ff;
      sum_in    = sum_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      data_in   = data_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_addr   = '0;
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               pos_in    = req_pos_x;
               val_in    = req_value;
               status_in = ST_OK;
               data_in   = '0;
               case (req_operation)
                  OP_INSERT: begin
                     if (req_pos_x > count_x) begin
                        status_in = ST_RANGE;
                        strobe_in = 1'b1;
                     end else if (full) begin
                        status_in = ST_FULL;
                        strobe_in = 1'b1;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  OP_APPEND: begin
                     strobe_in = 1'b1;
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(count_ff);
                        wr_data  = req_value;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE, OP_READ: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                        strobe_in = 1'b1;
                     end else if (req_pos_x >= count_x) begin
                        status_in = ST_RANGE;
                        strobe_in = 1'b1;
                     end else if (req_operation == OP_DELETE) begin
                        idx_in   = CW'(req_pos_x);
                        state_in = S_DEL_RD;
                     end else begin
                        rd_addr  = AW'(req_pos_x);
                        state_in = S_RD_OUT;
                     end
                  end
                  OP_SORT_ASC, OP_SORT_DSC: begin
                     desc_in  = (req_operation == OP_SORT_DSC);
                     idx_in   = CW'(1);
                     state_in = S_SRT_KEY;
                  end
                  OP_AVERAGE: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                        strobe_in = 1'b1;
                     end else begin
                        idx_in   = '0;
                        sum_in   = '0;
                        state_in = S_AVG_RD;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (XW'(idx_ff) > pos_ff) begin
               rd_addr  = AW'(idx_ff - 1'b1);
               state_in = S_INS_WR;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = AW'(pos_ff);
               wr_data   = val_ff;
               count_in  = count_ff + 1'b1;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff);
            wr_data  = rd_data;
            idx_in   = idx_ff - 1'b1;
            state_in = S_INS_RD;
         end
         S_DEL_RD: begin
            if (CW'(idx_ff + 1'b1) < count_ff) begin
               rd_addr  = AW'(idx_ff + 1'b1);
               state_in = S_DEL_WR;
            end else begin
               count_in  = count_ff - 1'b1;
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_DEL_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff);
            wr_data  = rd_data;
            idx_in   = idx_ff + 1'b1;
            state_in = S_DEL_RD;
         end
         S_SRT_KEY: begin
            if (idx_ff < count_ff) begin
               rd_addr  = AW'(idx_ff);
               state_in = S_SRT_KW;
            end else begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_SRT_KW: begin
            key_in   = rd_data;
            j_in     = idx_ff;
            state_in = S_SRT_RD;
         end
         S_SRT_RD: begin
            if (j_ff != '0) begin
               rd_addr  = AW'(j_ff - 1'b1);
               state_in = S_SRT_CMP;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = AW'(j_ff);
               wr_data  = key_ff;
               idx_in   = idx_ff + 1'b1;
               state_in = S_SRT_KEY;
            end
         end
         S_SRT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = AW'(j_ff);
            if (desc_ff ? (key_ff > rd_data) : (rd_data > key_ff)) begin
               wr_data  = rd_data;
               j_in     = j_ff - 1'b1;
               state_in = S_SRT_RD;
            end else begin
               wr_data  = key_ff;
               idx_in   = idx_ff + 1'b1;
               state_in = S_SRT_KEY;
            end
         end
         S_AVG_RD: begin
            if (idx_ff < count_ff) begin
               rd_addr  = AW'(idx_ff);
               idx_in   = idx_ff + 1'b1;
               state_in = S_AVG_ACC;
            end else begin
               div_start = 1'b1;
               state_in  = S_AVG_DIV;
            end
         end
         S_AVG_ACC: begin
            sum_in   = sum_ff + SW'(rd_data);
            state_in = S_AVG_RD;
         end
         S_AVG_DIV: begin
            if (div_done) begin
               wr_en     = 1'b1;
               wr_addr   = '0;
               wr_data   = avg_full[WORD_W-1:0];
               data_in   = avg_full[WORD_W-1:0];
               count_in  = CW'(1);
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_RD_OUT: begin
            data_in   = rd_data;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      idx_ff    <= idx_in;
      j_ff      <= j_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      key_ff    <= key_in;
      desc_ff   <= desc_in;
      sum_ff    <= sum_in;
      status_ff <= status_in;
      data_ff   <= data_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = 6'(count_ff);
   assign rsp_data   = data_ff;

endmodule

/* hdl/aid_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aid_checker
// port level checks for the word array core
// ----------------------------------------------------------------------------
module aid_checker import aid_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [1:0]         rsp_status,
   input logic [5:0]         rsp_count,
   input logic signed [31:0] rsp_data
);

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("transaction accepted without work or response");

   a_error_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |-> (rsp_data == 32'sd0))
      else $error("nonzero data on error");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY) |-> (rsp_count == 6'd0))
      else $error("empty status with words held");

endmodule

bind array_insert_delete_sort_average_core aid_checker u_aid_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_status (rsp_status),
   .rsp_count  (rsp_count),
   .rsp_data   (rsp_data)
);
